// ===== design/tfbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame byte stuffer package
// Shared constants for the frame encoder, its channels and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tfbs_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd1;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h5e;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h5d;
	localparam logic [BYTE_W-1:0] STUFF_XOR    = 8'h60;

	// Frame byte positions
	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] POS_HEADER = 3'd0;
	localparam logic [POS_W-1:0] POS_LAST_BODY = 3'd5;
	localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd6;

	// Payload bytes held in the shift register: id plus four value bytes
	localparam int unsigned SHIFT_W = BYTE_W + VALUE_W;

endpackage

`default_nettype wire

// ===== design/tfbs_if.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame byte stuffer channels
// Valid/ready channels for the input item and the stuffed line bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfbs_in_if import tfbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [BYTE_W-1:0]         msg_id;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output msg_id, output value, input ready);
	modport sink   (input valid, input msg_id, input value, output ready);
endinterface

interface tfbs_out_if import tfbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== design/telemetry_frame_byte_stuffer.sv =====
// Start: an accepted item sets the sequencer busy, after which the header
// byte is loaded into the output register. Throughput: one line byte per
// cycle unless the output stalls, 7 to 13 bytes per frame from a 40-bit
// shift register; a new item is taken the cycle after the last byte is loaded.
// Reset: arst_n clears the sequencer and output valid at once and restores
// header 0x5e and escape 0x5d; no clearing pass.
// ----------------------------------------------------------------------------
// Telemetry frame byte stuffer
// Builds header, id, value LE bytes and end-around-carry checksum, escaping
// post-header bytes matching header or escape, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_byte_stuffer import tfbs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	tfbs_in_if.sink                   frame_in,
	tfbs_out_if.source                frame_out
);

	logic [BYTE_W-1:0]  header_q;
	logic [BYTE_W-1:0]  escape_q;
	logic               busy_q;
	logic [POS_W-1:0]   pos_q;
	logic               esc_pend_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [BYTE_W-1:0]  sum_q;
	logic               ovalid_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               olast_q;

	logic               in_acc;
	logic               advance;
	logic [BYTE_W-1:0]  cur_byte;
	logic               needs_esc;
	logic [BYTE_W:0]    sum_wide;
	logic [BYTE_W-1:0]  sum_next;

	assign frame_in.ready = !busy_q;
	assign in_acc  = frame_in.valid && !busy_q;
	assign advance = busy_q && (!ovalid_q || frame_out.ready);

	always_comb begin
		if (pos_q == POS_CHECKSUM) begin
			cur_byte = sum_q;
		end else begin
			cur_byte = shift_q[BYTE_W-1:0];
		end
	end

	assign needs_esc = (cur_byte == header_q) || (cur_byte == escape_q);
	assign sum_wide  = {1'b0, sum_q} + {1'b0, cur_byte};
	// fold the carry back into the low byte
	assign sum_next  = sum_wide[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, sum_wide[BYTE_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			escape_q <= ESCAPE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_HEADER: header_q <= wr_data;
				REG_ESCAPE: escape_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pos_q      <= POS_HEADER;
			esc_pend_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q     <= 1'b1;
				pos_q      <= POS_HEADER;
				esc_pend_q <= 1'b0;
			end else if (advance) begin
				if (pos_q == POS_HEADER) begin
					pos_q <= pos_q + 1'b1;
				end else if (!esc_pend_q && needs_esc) begin
					esc_pend_q <= 1'b1;
				end else begin
					esc_pend_q <= 1'b0;
					if (pos_q == POS_CHECKSUM) begin
						busy_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (frame_out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			shift_q <= {frame_in.value, frame_in.msg_id};
			sum_q   <= header_q;
		end else if (advance) begin
			if (pos_q == POS_HEADER) begin
				obyte_q <= header_q;
				olast_q <= 1'b0;
			end else if (!esc_pend_q && needs_esc) begin
				obyte_q <= escape_q;
				olast_q <= 1'b0;
			end else begin
				obyte_q <= esc_pend_q ? (cur_byte ^ STUFF_XOR) : cur_byte;
				olast_q <= (pos_q == POS_CHECKSUM);
				if (pos_q <= POS_LAST_BODY) begin
					// drop the consumed byte and fold it into the checksum
					sum_q   <= sum_next;
					shift_q <= {{BYTE_W{1'b0}}, shift_q[SHIFT_W-1:BYTE_W]};
				end
			end
		end
	end

	assign frame_out.valid    = ovalid_q;
	assign frame_out.out_byte = obyte_q;
	assign frame_out.last     = olast_q;

endmodule

`default_nettype wire

// ===== design/tfbs_checker.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame byte stuffer checker
// Port-level checks on frame sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbs_checker import tfbs_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic              out_last
);

	// take no new item right after one is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	// a stalled byte holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output byte changed");

	// while idle, only the final byte of a frame may still wait
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_last)
		else $error("idle with a non-final byte pending");

	// a frame is still in progress while a non-final byte leaves
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |-> !in_ready)
		else $error("frame ended without a last byte");

endmodule

bind telemetry_frame_byte_stuffer tfbs_checker u_tfbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_byte  (frame_out.out_byte),
	.out_last  (frame_out.last)
);

`default_nettype wire

// ===== sim/tb_telemetry_frame_byte_stuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame byte stuffer testbench
// Sends id/value items under several header and escape settings, predicts the
// stuffed line bytes of each frame, and compares every line byte and its last
// flag in order. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_telemetry_frame_byte_stuffer;
	import tfbs_pkg::*;

	localparam int unsigned LINE_LATENCY = 2;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} line_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	tfbs_in_if  frame_in ();
	tfbs_out_if frame_out ();

	telemetry_frame_byte_stuffer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.frame_in  (frame_in),
		.frame_out (frame_out)
	);

	always #6 clk = ~clk;

	// Predictor copy of the marker registers
	logic [BYTE_W-1:0] header_val = HEADER_RESET;
	logic [BYTE_W-1:0] escape_val = ESCAPE_RESET;

	line_byte_t expected_line[$];
	int         errors = 0;
	bit         in_gaps_on = 1'b0;
	bit         out_stalls_on = 1'b0;
	int         stall_left = 0;

	// Build the frame, checksum and stuffed byte sequence for one item
	task automatic predict_frame(input logic [BYTE_W-1:0] id, input logic [VALUE_W-1:0] val);
		logic [BYTE_W-1:0] fr[7];
		logic [BYTE_W:0]   t;
		logic [BYTE_W-1:0] acc;
		fr[0] = header_val;
		fr[1] = id;
		for (int i = 0; i < 4; i++)
			fr[2 + i] = val[8*i +: 8];
		acc = fr[0];
		for (int i = 1; i < 6; i++) begin
			t = {1'b0, acc} + {1'b0, fr[i]};
			acc = t[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, t[BYTE_W]};
		end
		fr[6] = acc;
		expected_line.push_back('{data: fr[0], last: 1'b0});
		for (int i = 1; i < 7; i++) begin
			if (fr[i] == header_val || fr[i] == escape_val) begin
				expected_line.push_back('{data: escape_val, last: 1'b0});
				expected_line.push_back('{data: fr[i] ^ STUFF_XOR, last: (i == 6)});
			end else begin
				expected_line.push_back('{data: fr[i], last: (i == 6)});
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!in_gaps_on || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Bias bytes toward the markers and their XOR images
	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return header_val;
			2: return escape_val;
			3: return header_val ^ STUFF_XOR;
			4: return escape_val ^ STUFF_XOR;
			5: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Valid stays up across back-to-back items; lower it only ahead of a gap
	task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [VALUE_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid  <= 1'b1;
		frame_in.msg_id <= id;
		frame_in.value  <= val;
		do
			@(posedge clk);
		while (!frame_in.ready);
		predict_frame(id, val);
	endtask

	task automatic drain();
		frame_in.valid <= 1'b0;
		while (expected_line.size() != 0)
			@(posedge clk);
		repeat (LINE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_markers(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] esc);
		drain();
		wr_en    <= 1'b1;
		wr_index <= REG_HEADER;
		wr_data  <= hdr;
		@(posedge clk);
		header_val = hdr;
		wr_index <= REG_ESCAPE;
		wr_data  <= esc;
		@(posedge clk);
		escape_val = esc;
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Output side: random stalls on ready
	always @(posedge clk) begin
		int r;
		if (stall_left != 0) begin
			stall_left--;
			frame_out.ready <= 1'b0;
		end else if (!out_stalls_on) begin
			frame_out.ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				frame_out.ready <= 1'b1;
			end else begin
				frame_out.ready <= 1'b0;
				if (r < 92)
					stall_left = $urandom_range(0, 2);
				else if (r < 98)
					stall_left = $urandom_range(3, 7);
				else
					stall_left = $urandom_range(11, 29);
			end
		end
	end

	// Compare each accepted line byte against the oldest prediction
	always @(posedge clk) begin
		line_byte_t want;
		if (frame_out.valid && frame_out.ready) begin
			if (expected_line.size() == 0) begin
				$error("unexpected line byte: out_byte %h last %b",
					frame_out.out_byte, frame_out.last);
				errors++;
			end else begin
				want = expected_line.pop_front();
				if (frame_out.out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, frame_out.out_byte);
					errors++;
				end
				if (frame_out.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, frame_out.last);
					errors++;
				end
			end
		end
	end

	task automatic test_default_markers();
		send_frame(8'h00, 32'h0000_0000);
		send_frame(8'hff, 32'hffff_ffff);
		send_frame(8'h00, 32'h7fff_ffff);
		send_frame(8'hff, 32'h8000_0000);
		send_frame(8'h5e, 32'h5d5e_5d5e);
		send_frame(8'h5d, 32'h3e3d_3e3d);
		send_frame(8'h12, 32'h0000_5e00);
	endtask

	task automatic test_marker_special_cases();
		// escape image of one marker equals the other: XOR byte goes out raw
		set_markers(8'h5e, 8'h3e);
		send_frame(8'h3e, 32'h3e5e_3e5e);
		send_frame(8'h1e, 32'h5e1e_3e00);
		// header equal to escape: escape once
		set_markers(8'h7d, 8'h7d);
		send_frame(8'h7d, 32'h7d1d_7d00);
		send_frame(8'h1d, 32'h007d_1d7d);
		set_markers(8'h00, 8'hff);
		send_frame(8'h00, 32'hff00_ff00);
		send_frame(8'hff, 32'h6060_9f9f);
		set_markers(8'hff, 8'h00);
		send_frame(8'hff, 32'h00ff_0000);
		send_frame(8'h9f, 32'h6000_ff9f);
		set_markers(8'hff, 8'hff);
		send_frame(8'hff, 32'hffff_9fff);
	endtask

	task automatic test_random_traffic();
		logic [BYTE_W-1:0]  id;
		logic [VALUE_W-1:0] val;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_markers(HEADER_RESET, ESCAPE_RESET);
				1: set_markers(8'h00, 8'h00);
				2: set_markers(8'hff, 8'h00);
				default: set_markers(BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(0, 255)));
			endcase
			in_gaps_on    = (phase != 0) && ($urandom_range(0, 3) != 0);
			out_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 9) < 3) begin
					id  = BYTE_W'($urandom_range(0, 255));
					val = $urandom;
				end else begin
					id  = pick_byte();
					val = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
				end
				send_frame(id, val);
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_HEADER;
		wr_data         = '0;
		frame_in.valid  = 1'b0;
		frame_in.msg_id = '0;
		frame_in.value  = '0;
		frame_out.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_markers();
		test_marker_special_cases();
		test_random_traffic();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[telemetry_frame_byte_stuffer] OK");
		else
			$display("[telemetry_frame_byte_stuffer] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[telemetry_frame_byte_stuffer] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/tfbs_pkg.sv
design/tfbs_if.sv
design/telemetry_frame_byte_stuffer.sv
design/tfbs_checker.sv
sim/tb_telemetry_frame_byte_stuffer.sv
